/* rtl/least_primitive_root_finder_assert.svh */
// Assertion macros shared by the least primitive root finder RTL.
`ifndef LEAST_PRIMITIVE_ROOT_FINDER_ASSERT_SVH
`define LEAST_PRIMITIVE_ROOT_FINDER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LPRF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lprf_pkg.sv */
// Package: defaults, datapath operation codes and status bundle.
package lprf_pkg;

    localparam int VALUE_WIDTH_DEF = 16;
    localparam int MAX_FACTORS_DEF = 8;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PUSH_TWO,
        OP_HALVE,
        OP_SET_C,
        OP_MUL_CC,
        OP_DIV_VC,
        OP_PUSH_C,
        OP_TAKE_Q,
        OP_NEXT_C,
        OP_PUSH_V,
        OP_SET_G,
        OP_DIV_E,
        OP_TAKE_E,
        OP_DIV_B,
        OP_TAKE_B,
        OP_MUL_AB,
        OP_MUL_BB,
        OP_DIV_P,
        OP_TAKE_ACC,
        OP_TAKE_BB,
        OP_NEXT_Q,
        OP_NEXT_G,
        OP_OUT_ZERO,
        OP_OUT_ONE,
        OP_OUT_G
    } t_op;

    typedef struct packed {
        logic n_small;
        logic n_two;
        logic v_odd;
        logic cc_gt_v;
        logic rem_zero;
        logic div_busy;
        logic idx_end;
        logic e_zero;
        logic e_odd;
        logic acc_one;
    } t_stat;

endpackage

/* rtl/lprf_div.sv */
// Restoring divider, one quotient bit per cycle, double-width dividend.
module lprf_div import lprf_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [2*VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0]   i_divisor,
    output logic                     o_busy,
    output logic [2*VALUE_WIDTH-1:0] o_quot,
    output logic [VALUE_WIDTH-1:0]   o_rem
);
    localparam int W    = VALUE_WIDTH;
    localparam int DW   = 2 * VALUE_WIDTH;
    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] r_cnt;
    logic [W-1:0]    r_rem;
    logic [DW-1:0]   r_dd;
    logic [W-1:0]    r_dsr;
    logic [W:0]      n_sh;
    logic [W:0]      n_diff;
    logic            n_ge;

    always_comb begin
        n_sh   = {r_rem, r_dd[DW-1]};
        n_ge   = n_sh >= {1'b0, r_dsr};
        n_diff = n_sh - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dd  <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= n_ge ? n_diff[W-1:0] : n_sh[W-1:0];
            r_dd  <= {r_dd[DW-2:0], n_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_dd;
    assign o_rem  = r_rem;
endmodule

/* rtl/lprf_dpath.sv */
// Datapath: operand registers, factor list, multiplier and shared divider.
module lprf_dpath import lprf_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_FACTORS = MAX_FACTORS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_op                    i_op,
    input  logic [VALUE_WIDTH-1:0] i_modulus_value,
    output t_stat                  o_stat,
    output logic [VALUE_WIDTH-1:0] o_least_root
);
    localparam int W  = VALUE_WIDTH;
    localparam int DW = 2 * VALUE_WIDTH;
    localparam int CW = $clog2(MAX_FACTORS + 1);
    localparam int IW = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;

    logic [W-1:0]  r_n, r_nm1, r_v, r_c, r_g, r_e, r_b, r_acc, r_root;
    logic [DW-1:0] r_prod;
    logic [W-1:0]  r_fac [MAX_FACTORS];
    logic [CW-1:0] r_cnt, r_idx;

    logic [W-1:0]  n_mul_a, n_mul_b, n_push_val, n_dsr;
    logic [DW-1:0] n_dvd;
    logic          n_push, n_start;
    logic          w_busy;
    logic [DW-1:0] w_quot;
    logic [W-1:0]  w_rem;

    always_comb begin
        n_mul_a    = r_b;
        n_mul_b    = r_b;
        n_push     = 1'b0;
        n_push_val = r_v;
        n_start    = 1'b0;
        n_dvd      = r_prod;
        n_dsr      = r_n;
        case (i_op)
            OP_MUL_CC: begin
                n_mul_a = r_c;
                n_mul_b = r_c;
            end
            OP_MUL_AB: n_mul_a = r_acc;
            OP_PUSH_TWO: begin
                n_push     = 1'b1;
                n_push_val = W'(2);
            end
            OP_PUSH_C: begin
                n_push     = 1'b1;
                n_push_val = r_c;
            end
            OP_PUSH_V: n_push = r_v > W'(2);
            OP_DIV_VC: begin
                n_start = 1'b1;
                n_dvd   = {{W{1'b0}}, r_v};
                n_dsr   = r_c;
            end
            OP_DIV_E: begin
                n_start = 1'b1;
                n_dvd   = {{W{1'b0}}, r_nm1};
                n_dsr   = r_fac[r_idx[IW-1:0]];
            end
            OP_DIV_B: begin
                n_start = 1'b1;
                n_dvd   = {{W{1'b0}}, r_g};
            end
            OP_DIV_P: n_start = 1'b1;
            default: ;
        endcase
    end

    lprf_div #(.VALUE_WIDTH(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_start),
        .i_dividend (n_dvd),
        .i_divisor  (n_dsr),
        .o_busy     (w_busy),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= n_mul_a * n_mul_b;
        // list is capped: further distinct primes are dropped
        if (n_push && (r_cnt < CW'(MAX_FACTORS))) begin
            r_fac[r_cnt[IW-1:0]] <= n_push_val;
            r_cnt                <= r_cnt + 1'b1;
        end
        case (i_op)
            OP_LOAD: begin
                r_n   <= i_modulus_value;
                r_nm1 <= i_modulus_value - 1'b1;
                r_v   <= i_modulus_value - 1'b1;
                r_cnt <= '0;
            end
            OP_HALVE:    r_v   <= r_v >> 1;
            OP_SET_C:    r_c   <= W'(3);
            OP_PUSH_C:   r_v   <= w_quot[W-1:0];
            OP_TAKE_Q:   r_v   <= w_quot[W-1:0];
            OP_NEXT_C:   r_c   <= r_c + W'(2);
            OP_SET_G: begin
                r_g   <= W'(2);
                r_idx <= '0;
            end
            OP_TAKE_E:   r_e   <= w_quot[W-1:0];
            OP_TAKE_B: begin
                r_b   <= w_rem;
                r_acc <= W'(1);
            end
            OP_TAKE_ACC: r_acc <= w_rem;
            OP_TAKE_BB: begin
                r_b <= w_rem;
                r_e <= r_e >> 1;
            end
            OP_NEXT_Q:   r_idx <= r_idx + 1'b1;
            OP_NEXT_G: begin
                r_g   <= r_g + 1'b1;
                r_idx <= '0;
            end
            OP_OUT_ZERO: r_root <= '0;
            OP_OUT_ONE:  r_root <= W'(1);
            OP_OUT_G:    r_root <= r_g;
            default: ;
        endcase
    end

    always_comb begin
        o_stat.n_small  = r_n < W'(2);
        o_stat.n_two    = r_n == W'(2);
        o_stat.v_odd    = r_v[0];
        o_stat.cc_gt_v  = r_prod > {{W{1'b0}}, r_v};
        o_stat.rem_zero = w_rem == '0;
        o_stat.div_busy = w_busy;
        o_stat.idx_end  = r_idx == r_cnt;
        o_stat.e_zero   = r_e == '0;
        o_stat.e_odd    = r_e[0];
        o_stat.acc_one  = r_acc == W'(1);
    end

    assign o_least_root = r_root;
endmodule

/* rtl/lprf_ctrl.sv */
// Controller: sequences factoring, order tests and the result register.
module lprf_ctrl import lprf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_stall,
    input  t_stat i_stat,
    output t_op   o_op,
    output logic  o_stall,
    output logic  o_valid
);
    typedef enum logic [4:0] {
        S_IDLE, S_CHK, S_PUSH2, S_HALVE, S_SETC, S_MULCC, S_CMPCC,
        S_WAITV1, S_DIVV2, S_WAITV2, S_TAIL, S_SETG, S_TEST, S_WAITE,
        S_DIVB, S_WAITB, S_LOOP, S_DIVA, S_WAITA, S_MULBB, S_DIVBB,
        S_WAITBB, S_OUT0, S_OUT1, S_OUTG
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_free;
    t_op    n_op;

    assign w_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_op        = OP_NONE;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            S_IDLE: if (i_valid) begin
                n_op    = OP_LOAD;
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_stat.n_small)     n_state = S_OUT0;
                else if (i_stat.n_two)  n_state = S_OUT1;
                else if (i_stat.v_odd)  n_state = S_SETC;
                else                    n_state = S_PUSH2;
            end
            S_PUSH2: begin
                n_op    = OP_PUSH_TWO;
                n_state = S_HALVE;
            end
            S_HALVE: begin
                if (i_stat.v_odd) n_state = S_SETC;
                else              n_op    = OP_HALVE;
            end
            S_SETC: begin
                n_op    = OP_SET_C;
                n_state = S_MULCC;
            end
            S_MULCC: begin
                n_op    = OP_MUL_CC;
                n_state = S_CMPCC;
            end
            S_CMPCC: begin
                if (i_stat.cc_gt_v) begin
                    n_state = S_TAIL;
                end else begin
                    n_op    = OP_DIV_VC;
                    n_state = S_WAITV1;
                end
            end
            S_WAITV1: if (!i_stat.div_busy) begin
                if (i_stat.rem_zero) begin
                    n_op    = OP_PUSH_C;
                    n_state = S_DIVV2;
                end else begin
                    n_op    = OP_NEXT_C;
                    n_state = S_MULCC;
                end
            end
            S_DIVV2: begin
                n_op    = OP_DIV_VC;
                n_state = S_WAITV2;
            end
            S_WAITV2: if (!i_stat.div_busy) begin
                if (i_stat.rem_zero) begin
                    n_op    = OP_TAKE_Q;
                    n_state = S_DIVV2;
                end else begin
                    n_op    = OP_NEXT_C;
                    n_state = S_MULCC;
                end
            end
            S_TAIL: begin
                n_op    = OP_PUSH_V;
                n_state = S_SETG;
            end
            S_SETG: begin
                n_op    = OP_SET_G;
                n_state = S_TEST;
            end
            S_TEST: begin
                if (i_stat.idx_end) begin
                    n_state = S_OUTG;
                end else begin
                    n_op    = OP_DIV_E;
                    n_state = S_WAITE;
                end
            end
            S_WAITE: if (!i_stat.div_busy) begin
                n_op    = OP_TAKE_E;
                n_state = S_DIVB;
            end
            S_DIVB: begin
                n_op    = OP_DIV_B;
                n_state = S_WAITB;
            end
            S_WAITB: if (!i_stat.div_busy) begin
                // base congruent to zero: power is zero, test passes
                if (i_stat.rem_zero) begin
                    n_op    = OP_NEXT_Q;
                    n_state = S_TEST;
                end else begin
                    n_op    = OP_TAKE_B;
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_stat.e_zero) begin
                    n_op    = i_stat.acc_one ? OP_NEXT_G : OP_NEXT_Q;
                    n_state = S_TEST;
                end else if (i_stat.e_odd) begin
                    n_op    = OP_MUL_AB;
                    n_state = S_DIVA;
                end else begin
                    n_op    = OP_MUL_BB;
                    n_state = S_DIVBB;
                end
            end
            S_DIVA: begin
                n_op    = OP_DIV_P;
                n_state = S_WAITA;
            end
            S_WAITA: if (!i_stat.div_busy) begin
                n_op    = OP_TAKE_ACC;
                n_state = S_MULBB;
            end
            S_MULBB: begin
                n_op    = OP_MUL_BB;
                n_state = S_DIVBB;
            end
            S_DIVBB: begin
                n_op    = OP_DIV_P;
                n_state = S_WAITBB;
            end
            S_WAITBB: if (!i_stat.div_busy) begin
                n_op    = OP_TAKE_BB;
                n_state = S_LOOP;
            end
            S_OUT0: if (w_free) begin
                n_op        = OP_OUT_ZERO;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_OUT1: if (w_free) begin
                n_op        = OP_OUT_ONE;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_OUTG: if (w_free) begin
                n_op        = OP_OUT_G;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_op    = n_op;
    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_out_valid;
endmodule

/* rtl/least_primitive_root_finder.sv */
// Top level: least primitive root of a modulus, controller plus datapath.
//
//   channel  direction  handshake            payload
//   input    in         i_valid / o_stall    i_modulus_value
//   result   out        o_valid / i_stall    o_least_root
//
// One transaction at a time; every reduction runs on the shared divider. Factoring
// trial-divides by odd candidates up to sqrt(n-1); each order test costs one or two
// reductions per exponent bit.
// Reset is synchronous and clears only the controller and divider counter.
// A new modulus is taken while an earlier result still waits under i_stall.
module least_primitive_root_finder import lprf_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_FACTORS = MAX_FACTORS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [VALUE_WIDTH-1:0] i_modulus_value,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [VALUE_WIDTH-1:0] o_least_root
);
    t_op   w_op;
    t_stat w_stat;

    lprf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (w_stat),
        .o_op    (w_op),
        .o_stall (o_stall),
        .o_valid (o_valid)
    );

    lprf_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_FACTORS (MAX_FACTORS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (w_op),
        .i_modulus_value (i_modulus_value),
        .o_stat          (w_stat),
        .o_least_root    (o_least_root)
    );

`include "least_primitive_root_finder_assert.svh"

    `LPRF_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "not busy after accept")
    `LPRF_ASSERT_NOW(a_div_only_when_busy, w_stat.div_busy, o_stall, "divider runs while idle")
endmodule
